[rtl/smp_pkg.sv]
// shared types, codes and constants of the stun message parser
package smp_pkg;

  localparam int unsigned MaxPacket  = 1024;
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 152;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_VALUE    = 3'd2,
    PH_PAD      = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_ATTR_START = 2'd1,
    KIND_VALUE      = 2'd2,
    KIND_END        = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_SHORT     = 2'd1,
    STAT_BODY_LONG = 2'd2
  } status_e;

  typedef struct packed {
    kind_e        kind;
    status_e      status;
    logic [4:0]   method;
    logic [1:0]   class_bits;
    logic [31:0]  txid_high;
    logic [63:0]  txid_low;
    logic [15:0]  attr_code;
    logic [15:0]  attr_length;
    logic [7:0]   value_byte;
    logic         last_of_value;
    logic         last_in_run;
  } rec_t;

  // records produced by one parsed byte, first record in a
  typedef struct packed {
    logic [1:0] num;
    rec_t       a;
    rec_t       b;
  } push_t;

endpackage

[rtl/smp_parse_core.sv]
// parse state registers and per-byte record generation
module smp_parse_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       data_byte_i,
  input  logic [10:0]      packet_length_i,
  output smp_pkg::push_t   push_o
);

  logic [10:0]      pos_q, pos_d;
  smp_pkg::phase_e  phase_q, phase_d;
  logic [15:0]      type_q, type_d;
  logic [7:0]       lenhi_q, lenhi_d;
  logic             rej_q, rej_d;
  logic [31:0]      txu_q, txu_d;
  logic [63:0]      txl_q, txl_d;
  logic [15:0]      curt_q, curt_d;
  logic [15:0]      curl_q, curl_d;
  logic [15:0]      vrem_q, vrem_d;

  logic [10:0]      len_eff;
  logic [11:0]      next_pos;
  logic             end_v;
  logic [15:0]      attr_len_new;
  logic [16:0]      attr_end;
  logic             attr_fit;
  logic [15:0]      vrem_dec;

  assign len_eff      = (packet_length_i > 11'(smp_pkg::MaxPacket)) ?
                        11'(smp_pkg::MaxPacket) : packet_length_i;
  assign next_pos     = {1'b0, pos_q} + 12'd1;
  assign end_v        = (next_pos >= {1'b0, len_eff});
  // attribute length as completed by the fourth attribute header byte
  assign attr_len_new = {curl_q[7:0], data_byte_i};
  assign attr_end     = {5'b0, next_pos} + {1'b0, attr_len_new};
  assign attr_fit     = (attr_end <= {6'b0, len_eff});
  assign vrem_dec     = vrem_q - 16'd1;

  // next state
  always_comb begin
    logic [16:0]      body_sum;
    logic [12:0]      hdr_end;

    body_sum = '0;
    hdr_end  = {1'b0, next_pos} + 13'd4;

    pos_d   = pos_q;
    phase_d = phase_q;
    type_d  = type_q;
    lenhi_d = lenhi_q;
    rej_d   = rej_q;
    txu_d   = txu_q;
    txl_d   = txl_q;
    curt_d  = curt_q;
    curl_d  = curl_q;
    vrem_d  = vrem_q;

    case (phase_q)
      smp_pkg::PH_HEADER: begin
        if (pos_q < 11'd2) begin
          type_d = {type_q[7:0], data_byte_i};
        end else if (pos_q == 11'd2) begin
          lenhi_d = data_byte_i;
        end else if (pos_q == 11'd3) begin
          body_sum = {1'b0, lenhi_q, data_byte_i} + 17'(smp_pkg::HdrBytes);
          rej_d    = ({6'b0, len_eff} < body_sum);
        end else if (pos_q >= 11'd8 && pos_q < 11'd12) begin
          txu_d = {txu_q[23:0], data_byte_i};
        end else if (pos_q >= 11'd12) begin
          txl_d = {txl_q[55:0], data_byte_i};
        end
        if (pos_q == 11'(smp_pkg::HdrBytes - 1)) begin
          if (rej_q) begin
            phase_d = smp_pkg::PH_DONE;
          end else begin
            phase_d = (len_eff < 11'(smp_pkg::HdrBytes + 4)) ?
                      smp_pkg::PH_DONE : smp_pkg::PH_ATTR_HDR;
          end
        end
      end
      smp_pkg::PH_ATTR_HDR: begin
        if (!pos_q[1]) begin
          curt_d = {curt_q[7:0], data_byte_i};
        end else begin
          curl_d = attr_len_new;
        end
        if (pos_q[1:0] == 2'd3) begin
          if (!attr_fit) begin
            phase_d = smp_pkg::PH_DONE;
          end else if (attr_len_new == 16'd0) begin
            phase_d = (hdr_end > {2'b0, len_eff}) ?
                      smp_pkg::PH_DONE : smp_pkg::PH_ATTR_HDR;
          end else begin
            vrem_d  = attr_len_new;
            phase_d = smp_pkg::PH_VALUE;
          end
        end
      end
      smp_pkg::PH_VALUE: begin
        vrem_d = vrem_dec;
        if (vrem_dec == 16'd0) begin
          if (next_pos[1:0] == 2'd0) begin
            phase_d = (hdr_end > {2'b0, len_eff}) ?
                      smp_pkg::PH_DONE : smp_pkg::PH_ATTR_HDR;
          end else begin
            phase_d = smp_pkg::PH_PAD;
          end
        end
      end
      smp_pkg::PH_PAD: begin
        // padding skipped up to the next 4-byte boundary
        if (next_pos[1:0] == 2'd0) begin
          phase_d = (hdr_end > {2'b0, len_eff}) ?
                    smp_pkg::PH_DONE : smp_pkg::PH_ATTR_HDR;
        end
      end
      default: begin
      end
    endcase

    if (end_v) begin
      // datagram done: back to the reset state for the next one
      pos_d   = '0;
      phase_d = smp_pkg::PH_HEADER;
      type_d  = '0;
      lenhi_d = '0;
      rej_d   = 1'b0;
      txu_d   = '0;
      txl_d   = '0;
      curt_d  = '0;
      curl_d  = '0;
      vrem_d  = '0;
    end else begin
      pos_d = next_pos[10:0];
    end
  end

  // records of the current byte
  always_comb begin
    logic             main_v;
    smp_pkg::rec_t    main_rec;
    smp_pkg::rec_t    end_rec;

    main_v   = 1'b0;
    main_rec = '0;
    end_rec  = '0;

    case (phase_q)
      smp_pkg::PH_HEADER: begin
        if (pos_q == 11'(smp_pkg::HdrBytes - 1) && !rej_q) begin
          main_v              = 1'b1;
          main_rec.kind       = smp_pkg::KIND_HEADER;
          main_rec.method     = type_q[4:0];
          main_rec.class_bits = {type_q[8], type_q[4]};
          main_rec.txid_high  = txu_q;
          main_rec.txid_low   = {txl_q[55:0], data_byte_i};
        end
      end
      smp_pkg::PH_ATTR_HDR: begin
        if (pos_q[1:0] == 2'd3 && attr_fit) begin
          main_v               = 1'b1;
          main_rec.kind        = smp_pkg::KIND_ATTR_START;
          main_rec.attr_code   = curt_q;
          main_rec.attr_length = attr_len_new;
        end
      end
      smp_pkg::PH_VALUE: begin
        main_v                 = 1'b1;
        main_rec.kind          = smp_pkg::KIND_VALUE;
        main_rec.attr_code     = curt_q;
        main_rec.attr_length   = curl_q;
        main_rec.value_byte    = data_byte_i;
        main_rec.last_of_value = (vrem_dec == 16'd0);
      end
      default: begin
      end
    endcase

    end_rec.kind        = smp_pkg::KIND_END;
    end_rec.last_in_run = 1'b1;
    if (pos_q < 11'(smp_pkg::HdrBytes - 1)) begin
      end_rec.status = smp_pkg::STAT_SHORT;
    end else if (rej_q) begin
      end_rec.status = smp_pkg::STAT_BODY_LONG;
    end else begin
      end_rec.status = smp_pkg::STAT_OK;
    end
    main_rec.last_in_run = !end_v;

    push_o.num = {1'b0, main_v} + {1'b0, end_v};
    push_o.a   = main_v ? main_rec : end_rec;
    push_o.b   = end_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= smp_pkg::PH_HEADER;
      type_q  <= '0;
      lenhi_q <= '0;
      rej_q   <= 1'b0;
      txu_q   <= '0;
      txl_q   <= '0;
      curt_q  <= '0;
      curl_q  <= '0;
      vrem_q  <= '0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      type_q  <= type_d;
      lenhi_q <= lenhi_d;
      rej_q   <= rej_d;
      txu_q   <= txu_d;
      txl_q   <= txl_d;
      curt_q  <= curt_d;
      curl_q  <= curl_d;
      vrem_q  <= vrem_d;
    end
  end

endmodule

[rtl/smp_out_fifo.sv]
// result record queue, up to two writes and one read per cycle
module smp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_en_i,
  input  smp_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             pop_i,
  output smp_pkg::rec_t    rec_o
);

  smp_pkg::rec_t                    mem_q [smp_pkg::FifoDepth];
  logic [smp_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [smp_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [smp_pkg::FifoCntW-1:0]     count_q, count_d;
  logic [1:0]                       num;
  logic                             pop;

  assign num     = push_en_i ? push_i.num : 2'd0;
  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign room_o  = (count_q <= smp_pkg::FifoCntW'(smp_pkg::FifoDepth - 2));
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + smp_pkg::FifoPtrW'(num);
    rd_ptr_d = rd_ptr_q + smp_pkg::FifoPtrW'(pop);
    count_d  = count_q + smp_pkg::FifoCntW'(num) - smp_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (num == 2'd2) begin
      mem_q[wr_ptr_q + smp_pkg::FifoPtrW'(1)] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/stun_message_parser_unit.sv]
// top level: input register, byte parser and result queue of the stun message parser
// flow: an accepted byte waits in the input register and is parsed when the result queue has
//   room; its records are written to the queue and leave the output from there
// throughput: one byte per cycle while the result queue has room; a byte that also ends the
//   datagram gives two records that leave one by one, the 4-entry result queue absorbs these
// reset: rst_ni clears parse state, input valid flag and queue pointers; s_axis_tready_o is high
module stun_message_parser_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] data_byte, [18:8] packet_length
  input  logic [smp_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [6:2] method, [8:7] class_bits, [40:9] txid_high, [104:41] txid_low,
  // [120:105] attr_code, [136:121] attr_length, [144:137] value_byte, [145] last_of_value
  output logic [smp_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]                      m_axis_tuser_o,
  // last_in_run
  output logic                            m_axis_tlast_o
);

  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic [10:0]        in_len_q;
  logic               accept;
  logic               fire;
  logic               room;
  smp_pkg::push_t     push;
  smp_pkg::rec_t      rec;

  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_len_q  <= s_axis_tdata_i[18:8];
    end
  end

  smp_parse_core u_parse_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .data_byte_i     (in_byte_q),
    .packet_length_i (in_len_q),
    .push_o          (push)
  );

  smp_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (fire),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (m_axis_tvalid_o),
    .pop_i     (m_axis_tready_i),
    .rec_o     (rec)
  );

  assign m_axis_tdata_o = {6'b0, rec.last_of_value, rec.value_byte, rec.attr_length,
                           rec.attr_code, rec.txid_low, rec.txid_high, rec.class_bits,
                           rec.method, rec.status};
  assign m_axis_tuser_o = rec.kind;
  assign m_axis_tlast_o = rec.last_in_run;

endmodule

[rtl/smp_checker.sv]
// port-level checks of the stun message parser, bound to the top level
module smp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [smp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [1:0]                    m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);

  // a stalled result transfer keeps its record
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output record changed while stalled");

  // the end record always closes the run of its byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == smp_pkg::KIND_END) |-> m_axis_tlast_o)
    else $error("end record without tlast");

  // only the end record carries a status
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != smp_pkg::KIND_END) |->
      (m_axis_tdata_o[1:0] == 2'd0))
    else $error("status on a non-end record");

  // the final value flag appears only on value records
  a_last_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[145] |-> (m_axis_tuser_o == smp_pkg::KIND_VALUE))
    else $error("last_of_value on a non-value record");

endmodule

bind stun_message_parser_unit smp_checker u_smp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
